FILE: design/assert_macros.svh
// Assertion macros used by the checker module of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a reset that disables the check.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication form of the clocked assertion.
`define ASSERT_IMPLY(lbl, clk, rst, cond, prop, msg) \
   `ASSERT_CLK(lbl, clk, rst, (cond) |-> (prop), msg)

`endif

FILE: design/hia_pkg.sv
// Package with the constants, coefficient set and types of the heat index block.
`timescale 1ns / 1ps
`default_nettype none

package hia_pkg;

   localparam int COEF_FRAC_BITS = 32;

   localparam int TempW     = 8;
   localparam int HumW      = 7;
   localparam int FeelsW    = 13;
   localparam int CsrIndexW = 1;
   localparam int CsrDataW  = 8;

   localparam int CoefW     = COEF_FRAC_BITS + 6;
   localparam int MonoW     = 30;
   localparam int SumW      = COEF_FRAC_BITS + 16;
   localparam int NumTerms  = 9;
   localparam int NumGroups = 3;
   localparam int PipeDepth = 6;

   localparam int HumidityMax = 100;
   localparam int FeelsMax    = 4095;
   localparam int FeelsMin    = -4096;

   localparam logic signed [TempW-1:0] TempThresholdReset    = 8'sd88;
   localparam logic        [HumW-1:0]  HumidityThresholdReset = 7'd40;

   localparam logic [63:0] DecScale = 64'd100000000;

   // Coefficient magnitudes in units of 1e-8 and their signs, in the order
   // 1, T, H, T*H, T*T, H*H, T*T*H, T*H*H, T*T*H*H.
   localparam logic [63:0] CoefMag [NumTerms] = '{
      64'd4237900000, 64'd204901523, 64'd1014333127, 64'd22475541, 64'd683783,
      64'd5481717, 64'd122874, 64'd85282, 64'd199
   };
   localparam logic CoefNeg [NumTerms] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
                                           1'b0, 1'b0, 1'b1};

   typedef enum logic [CsrIndexW-1:0] {
      CSR_TEMP_THRESHOLD     = 1'b0,
      CSR_HUMIDITY_THRESHOLD = 1'b1
   } csr_index_type;

   // Rounds a decimal magnitude half up to the fixed point grid by binary
   // long division and applies the coefficient sign.
   function automatic logic signed [CoefW:0] coef_fixed(int idx);
      logic [63:0] mag;
      logic [63:0] quo;
      logic [63:0] rem;
      logic [63:0] frac;
      logic [63:0] fixed;
      logic signed [CoefW:0] pos;
      mag  = CoefMag[idx];
      quo  = mag / DecScale;
      rem  = mag % DecScale;
      frac = '0;
      for (int i = 0; i < COEF_FRAC_BITS + 1; i++) begin
         rem  = rem << 1;
         frac = frac << 1;
         if (rem >= DecScale) begin
            rem     = rem - DecScale;
            frac[0] = 1'b1;
         end
      end
      frac  = (frac + 64'd1) >> 1;
      fixed = (quo << COEF_FRAC_BITS) + frac;
      pos   = $signed({1'b0, fixed[CoefW-1:0]});
      return CoefNeg[idx] ? -pos : pos;
   endfunction

   localparam logic signed [CoefW:0] CoefFix [NumTerms] = '{
      coef_fixed(0), coef_fixed(1), coef_fixed(2), coef_fixed(3), coef_fixed(4),
      coef_fixed(5), coef_fixed(6), coef_fixed(7), coef_fixed(8)
   };

   localparam logic signed [SumW-1:0] RoundBias = SumW'((64'd1 << COEF_FRAC_BITS) - 64'd1);

endpackage

`default_nettype wire

FILE: design/heat_index_advisory_top.sv
// Pipelined heat index advisory: threshold test and nine-term heat index regression.
//
// Requests arrive on the req_ channel (temperature in degrees F, humidity in
// percent) under a valid and stall handshake; a request is taken at a clock
// edge with req_valid high and req_stall low. Every request yields exactly one
// response on the rsp_ channel, in order: the advisory flag and the feels-like
// temperature, which is zero when no advisory is raised.
// The pipeline has seven register stages: clamp and threshold test, squares
// and cross product, higher monomials, coefficient products, two adder
// levels, and rounding with saturation into the output register. One request
// is taken in every cycle in which req_stall is low. When the receiver stalls,
// the output register holds its response and the stages behind it keep
// filling their empty slots; req_stall rises only once every stage holds a
// request. The user must write the thresholds on the csr_ port only while
// the block is idle; the block itself has no check for this. Reset empties
// the pipeline, holds req_stall high and restores the thresholds to 88
// degrees F and 40 percent.
`timescale 1ns / 1ps
`default_nettype none

module heat_index_advisory_top
   import hia_pkg::*;
(
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  logic signed [TempW-1:0]  req_temperature_f,
   input  wire  logic [HumW-1:0]          req_humidity_pct,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic                           rsp_advisory,
   output logic signed [FeelsW-1:0]       rsp_feels_like_f,
   input  wire                            csr_write_enable,
   input  wire  logic [CsrIndexW-1:0]     csr_index,
   input  wire  logic [CsrDataW-1:0]      csr_write_data
);

   logic signed [TempW-1:0] temp_thr_ff;
   logic [HumW-1:0]         hum_thr_ff;

   logic [PipeDepth-1:0] valid_ff;
   logic [PipeDepth:0]   ready;

   logic signed [TempW-1:0] t1_ff, t2_ff;
   logic [HumW-1:0]         h1_ff, h2_ff;
   logic [HumW-1:0]         h1_in;
   logic                    adv1_in;
   logic [5:0]              adv_ff;

   logic signed [15:0] tt2_ff, th2_ff;
   logic [13:0]        hh2_ff;

   logic signed [MonoW-1:0] mono_ff [NumTerms];
   logic signed [MonoW-1:0] mono_in [NumTerms];
   logic signed [SumW-1:0]  term_ff [NumTerms];
   logic signed [SumW-1:0]  term_in [NumTerms];
   logic signed [SumW-1:0]  psum_ff [NumGroups];
   logic signed [SumW-1:0]  psum_in [NumGroups];
   logic signed [SumW-1:0]  sum_ff;

   logic signed [SumW-1:0]   biased;
   logic signed [SumW-1:0]   whole;
   logic signed [FeelsW-1:0] feels_in;
   logic                     rsp_valid_ff;
   logic                     rsp_advisory_ff;
   logic signed [FeelsW-1:0] rsp_feels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_thr_ff <= TempThresholdReset;
         hum_thr_ff  <= HumidityThresholdReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TEMP_THRESHOLD:     temp_thr_ff <= $signed(csr_write_data[TempW-1:0]);
            CSR_HUMIDITY_THRESHOLD: hum_thr_ff  <= csr_write_data[HumW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ready[PipeDepth] = !rsp_valid_ff || !rsp_stall;
      for (int k = PipeDepth - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign req_stall = reset || !ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready[0]) valid_ff[0] <= req_valid;
         for (int k = 1; k < PipeDepth; k++) begin
            if (ready[k]) valid_ff[k] <= valid_ff[k-1];
         end
         if (ready[PipeDepth]) rsp_valid_ff <= valid_ff[PipeDepth-1];
      end
   end

   always_comb begin
      h1_in   = (req_humidity_pct > HumW'(HumidityMax)) ? HumW'(HumidityMax)
                                                         : req_humidity_pct;
      adv1_in = (req_temperature_f >= temp_thr_ff) && (h1_in >= hum_thr_ff);
   end

   always_comb begin
      mono_in[0] = MonoW'(1);
      mono_in[1] = MonoW'(t2_ff);
      mono_in[2] = MonoW'($signed({1'b0, h2_ff}));
      mono_in[3] = MonoW'(th2_ff);
      mono_in[4] = MonoW'(tt2_ff);
      mono_in[5] = MonoW'($signed({1'b0, hh2_ff}));
      mono_in[6] = MonoW'(tt2_ff * $signed({1'b0, h2_ff}));
      mono_in[7] = MonoW'(th2_ff * $signed({1'b0, h2_ff}));
      mono_in[8] = MonoW'(tt2_ff * $signed({1'b0, hh2_ff}));
   end

   always_comb begin
      for (int i = 0; i < NumTerms; i++) begin
         term_in[i] = SumW'(CoefFix[i] * mono_ff[i]);
      end
      for (int j = 0; j < NumGroups; j++) begin
         psum_in[j] = term_ff[3*j] + term_ff[3*j+1] + term_ff[3*j+2];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         t1_ff     <= req_temperature_f;
         h1_ff     <= h1_in;
         adv_ff[0] <= adv1_in;
      end
      if (ready[1]) begin
         t2_ff     <= t1_ff;
         h2_ff     <= h1_ff;
         tt2_ff    <= 16'(t1_ff * t1_ff);
         th2_ff    <= 16'(t1_ff * $signed({1'b0, h1_ff}));
         hh2_ff    <= 14'(h1_ff * h1_ff);
         adv_ff[1] <= adv_ff[0];
      end
      if (ready[2]) begin
         mono_ff   <= mono_in;
         adv_ff[2] <= adv_ff[1];
      end
      if (ready[3]) begin
         term_ff   <= term_in;
         adv_ff[3] <= adv_ff[2];
      end
      if (ready[4]) begin
         psum_ff   <= psum_in;
         adv_ff[4] <= adv_ff[3];
      end
      if (ready[5]) begin
         sum_ff    <= psum_ff[0] + psum_ff[1] + psum_ff[2];
         adv_ff[5] <= adv_ff[4];
      end
   end

   // The bias makes the arithmetic shift truncate toward zero for negative sums.
   always_comb begin
      biased = sum_ff + (sum_ff[SumW-1] ? RoundBias : '0);
      whole  = biased >>> COEF_FRAC_BITS;
      if (!adv_ff[5]) begin
         feels_in = '0;
      end else if (whole > SumW'(FeelsMax)) begin
         feels_in = FeelsW'(FeelsMax);
      end else if (whole < SumW'(FeelsMin)) begin
         feels_in = FeelsW'(FeelsMin);
      end else begin
         feels_in = whole[FeelsW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[PipeDepth]) begin
         rsp_advisory_ff <= adv_ff[5];
         rsp_feels_ff    <= feels_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_advisory     = rsp_advisory_ff;
   assign rsp_feels_like_f = rsp_feels_ff;

endmodule

`default_nettype wire

FILE: design/hia_checker.sv
// Port-level checker for the heat index block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hia_checker
   import hia_pkg::*;
(
   input wire                           clock,
   input wire                           reset,
   input wire                           req_valid,
   input wire                           req_stall,
   input wire                           rsp_valid,
   input wire                           rsp_stall,
   input wire                           rsp_advisory,
   input wire logic signed [FeelsW-1:0] rsp_feels_like_f
);

   logic [3:0] inflight_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_ff + 4'(req_take) - 4'(rsp_take);
      end
   end

   `ASSERT_IMPLY(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, ##1 (rsp_valid && $stable(rsp_advisory) && $stable(rsp_feels_like_f)), "Stalled response changed.")
   `ASSERT_IMPLY(a_zero_without_advisory, clock, reset, rsp_valid && !rsp_advisory, rsp_feels_like_f == '0, "Nonzero value without an advisory.")
   `ASSERT_IMPLY(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall, "Request stalled while the output register is empty.")
   `ASSERT_CLK(a_inflight_bound, clock, reset, inflight_ff <= 4'(PipeDepth + 1), "More requests in flight than register stages.")
   `ASSERT_IMPLY(a_rsp_has_request, clock, reset, rsp_valid, inflight_ff != '0, "Response without an outstanding request.")

endmodule

bind heat_index_advisory_top hia_checker u_checker (.*);

`default_nettype wire

FILE: tb/heat_index_advisory_top_tb.sv
// Self-checking regression bench for the pipelined heat index advisory block.
`timescale 1ns / 1ps

module heat_index_advisory_top_tb;
   import hia_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 150;
   localparam int DRAIN_CYCLES   = 10;
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASE_ITEMS    = 100;

   localparam longint unsigned WEIGHT_E8 [9] = '{
      64'd4237900000, 64'd204901523, 64'd1014333127, 64'd22475541, 64'd683783,
      64'd5481717, 64'd122874, 64'd85282, 64'd199
   };
   localparam bit WEIGHT_NEG [9] = '{1, 0, 0, 1, 1, 1, 0, 0, 1};

   typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_type;

   typedef struct {
      logic signed [TempW-1:0]  temperature;
      logic [HumW-1:0]          humidity;
      logic                     advisory;
      logic signed [FeelsW-1:0] feels_like;
   } heat_reading_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [TempW-1:0]  req_temperature_f = '0;
   logic [HumW-1:0]          req_humidity_pct = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_advisory;
   logic signed [FeelsW-1:0] rsp_feels_like_f;
   logic                     csr_write_enable = 1'b0;
   csr_index_type            csr_index = CSR_TEMP_THRESHOLD;
   logic [CsrDataW-1:0]      csr_write_data = '0;

   heat_reading_type        awaiting_readings [$];
   logic signed [TempW-1:0] temp_limit = 8'sd88;
   logic [HumW-1:0]         hum_limit = 7'd40;
   int                      mismatches = 0;
   int                      idle_cycles = 0;
   int                      burst_left = 0;
   rx_mode_type             receiver_mode = RX_FREE;
   int                      hold_requests = 0;
   int                      hold_seen = 0;
   int                      hold_left = 0;
   int                      stall_run = 0;

   heat_index_advisory_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_temperature_f (req_temperature_f),
      .req_humidity_pct  (req_humidity_pct),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_advisory      (rsp_advisory),
      .rsp_feels_like_f  (rsp_feels_like_f),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint weight_q32(int k);
      logic [127:0] scaled;
      longint       w;
      scaled = ({64'd0, WEIGHT_E8[k]} << (COEF_FRAC_BITS + 1)) / 128'd100000000;
      w = longint'((scaled + 128'd1) >> 1);
      return WEIGHT_NEG[k] ? -w : w;
   endfunction

   function automatic heat_reading_type heat_index_of(logic signed [TempW-1:0] t_in,
                                                      logic [HumW-1:0] h_in);
      heat_reading_type r;
      longint           t;
      longint           h;
      longint           t_min;
      longint           h_min;
      longint           sum;
      longint           mag;
      longint           mono [9];
      t     = t_in;
      h     = (h_in > 7'd100) ? 100 : longint'(h_in);
      t_min = temp_limit;
      h_min = longint'(hum_limit);
      r.temperature = t_in;
      r.humidity    = h_in;
      r.advisory    = 1'b0;
      r.feels_like  = '0;
      if (t >= t_min && h >= h_min) begin
         mono[0] = 1;
         mono[1] = t;
         mono[2] = h;
         mono[3] = t * h;
         mono[4] = t * t;
         mono[5] = h * h;
         mono[6] = t * t * h;
         mono[7] = t * h * h;
         mono[8] = t * t * h * h;
         sum = 0;
         for (int k = 0; k < 9; k++) begin
            sum += weight_q32(k) * mono[k];
         end
         if (sum >= 0) begin
            mag = sum >>> COEF_FRAC_BITS;
            r.feels_like = (mag > FeelsMax) ? FeelsW'(FeelsMax) : FeelsW'(mag);
         end else begin
            mag = (-sum) >>> COEF_FRAC_BITS;
            r.feels_like = (mag > -FeelsMin) ? FeelsW'(FeelsMin) : FeelsW'(-mag);
         end
         r.advisory = 1'b1;
      end
      return r;
   endfunction

   // In the light and heavy modes the receiver stalls in runs of random length,
   // and it holds off for a long stretch whenever a test asks for it.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run <= stall_run - 1;
      end else begin
         case (receiver_mode)
            RX_FREE: begin
               rsp_stall <= 1'b0;
               stall_run <= 0;
            end
            RX_LIGHT: begin
               if ($urandom_range(0, 3) == 0) begin
                  rsp_stall <= 1'b1;
                  stall_run <= $urandom_range(0, 2);
               end else begin
                  rsp_stall <= 1'b0;
                  stall_run <= $urandom_range(0, 10);
               end
            end
            default: begin
               if ($urandom_range(0, 2) != 0) begin
                  rsp_stall <= 1'b1;
                  stall_run <= $urandom_range(0, 6);
               end else begin
                  rsp_stall <= 1'b0;
                  stall_run <= $urandom_range(0, 3);
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin : check_response
      heat_reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaiting_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: advisory=%0b feels_like=%0d",
                        rsp_advisory, rsp_feels_like_f);
         end else begin
            want = awaiting_readings.pop_front();
            if (rsp_advisory !== want.advisory || rsp_feels_like_f !== want.feels_like) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch T=%0d H=%0d: expected advisory=%0b feels_like=%0d, got advisory=%0b feels_like=%0d",
                           want.temperature, want.humidity, want.advisory, want.feels_like,
                           rsp_advisory, rsp_feels_like_f);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("heat_index_advisory_top regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_reading(input logic signed [TempW-1:0] t, input logic [HumW-1:0] h);
      req_valid         <= 1'b1;
      req_temperature_f <= t;
      req_humidity_pct  <= h;
      do @(posedge clock); while (req_stall);
      awaiting_readings.push_back(heat_index_of(t, h));
   endtask

   task automatic sender_idle(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Sends one request; when the current burst is used up, starts a new one after a random gap, which may be zero.
   task automatic offer_reading(input logic signed [TempW-1:0] t, input logic [HumW-1:0] h);
      int gap;
      send_reading(t, h);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) sender_idle(gap);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_drained();
      while (awaiting_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_thresholds(input logic [CsrDataW-1:0] temp_data,
                                 input logic [CsrDataW-1:0] hum_data);
      sender_idle(0);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_TEMP_THRESHOLD;
      csr_write_data   <= temp_data;
      @(posedge clock);
      temp_limit = temp_data;
      csr_index      <= CSR_HUMIDITY_THRESHOLD;
      csr_write_data <= hum_data;
      @(posedge clock);
      hum_limit = hum_data[HumW-1:0];
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_reset_thresholds();
      receiver_mode <= RX_LIGHT;
      offer_reading(8'sd88, 7'd40);
      offer_reading(8'sd87, 7'd40);
      offer_reading(8'sd88, 7'd39);
      offer_reading(8'sd127, 7'd127);
      offer_reading(-8'sd128, 7'd127);
      offer_reading(8'sd127, 7'd0);
   endtask

   task automatic test_low_thresholds();
      set_thresholds(8'h80, 8'h00);
      offer_reading(-8'sd128, 7'd0);
      offer_reading(-8'sd128, 7'd100);
      offer_reading(-8'sd128, 7'd127);
      offer_reading(8'sd127, 7'd0);
      offer_reading(8'sd127, 7'd101);
      offer_reading(8'sd0, 7'd0);
      offer_reading(-8'sd1, 7'd64);
      offer_reading(8'sd1, 7'd63);
   endtask

   task automatic test_high_thresholds();
      set_thresholds(8'h7F, 8'h64);
      offer_reading(8'sd127, 7'd100);
      offer_reading(8'sd127, 7'd127);
      offer_reading(8'sd126, 7'd127);
      offer_reading(8'sd127, 7'd99);
   endtask

   task automatic test_unreachable_humidity();
      // The top data bit of the humidity write is dropped, leaving 101.
      set_thresholds(8'h00, 8'hE5);
      offer_reading(8'sd127, 7'd127);
      offer_reading(8'sd50, 7'd100);
      set_thresholds(8'h00, 8'h7F);
      offer_reading(8'sd127, 7'd127);
   endtask

   task automatic test_random_readings();
      logic [CsrDataW-1:0]     t_data;
      logic [CsrDataW-1:0]     h_data;
      logic signed [TempW-1:0] t;
      logic [HumW-1:0]         h;
      int                      lo;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               t_data = 8'h80;
               h_data = 8'h00;
            end
            1: begin
               t_data = 8'h7F;
               h_data = 8'h64;
            end
            default: begin
               t_data = CsrDataW'($urandom);
               h_data = CsrDataW'($urandom);
            end
         endcase
         set_thresholds(t_data, h_data);
         receiver_mode <= rx_mode_type'(phase % 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 3) != 0) begin
               lo = int'(temp_limit) + 128;
               t  = TempW'($urandom_range(255, lo) - 128);
               h  = (hum_limit <= 7'd100) ? HumW'($urandom_range(127, int'(hum_limit)))
                                          : HumW'($urandom);
            end else begin
               t = TempW'($urandom);
               h = HumW'($urandom);
            end
            offer_reading(t, h);
         end
      end
   endtask

   task automatic test_backpressure();
      set_thresholds(8'h80, 8'h00);
      receiver_mode <= RX_FREE;
      hold_requests <= hold_requests + 1;
      for (int n = 0; n < 40; n++) begin
         send_reading(TempW'($urandom), HumW'($urandom));
      end
      sender_idle(0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_thresholds();
      test_low_thresholds();
      test_high_thresholds();
      test_unreachable_humidity();
      test_random_readings();
      test_backpressure();
      receiver_mode <= RX_LIGHT;
      wait_drained();
      if (mismatches == 0 && awaiting_readings.size() == 0) begin
         $display("heat_index_advisory_top regression: pass");
      end else begin
         $display("heat_index_advisory_top regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/hia_pkg.sv
design/heat_index_advisory_top.sv
design/hia_checker.sv
tb/heat_index_advisory_top_tb.sv
